// ===== sv/tcf_pkg.sv =====
// shared types, constants and microcode table of the tilt filter
package tcf_pkg;

    localparam int ACC_W   = 36;
    localparam int PROD_W  = 36;
    localparam int PC_W    = 5;
    localparam int QUO_W   = 24;
    localparam int REM_W   = 10;
    localparam int CNT_W   = 5;
    localparam int MHI_LSB = 8;
    localparam int MHI_W   = 26;
    localparam int RECIP_W = 25;
    localparam int RECIP_SH = 26;
    localparam int EST_W   = MHI_W + RECIP_W;

    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd3;
    localparam logic [CNT_W-1:0] DS_EST    = 5'd3;
    localparam logic [CNT_W-1:0] DS_BACK   = 5'd2;
    localparam logic [CNT_W-1:0] DS_FIX    = 5'd1;
    localparam logic [REM_W:0]   DIVISOR   = 11'd625;
    localparam logic [ACC_W-1:0] ROUND_ADD = 36'd312;
    localparam logic [RECIP_W-1:0] RECIP_625 = 25'd27487790;

    localparam logic signed [17:0] RECIP_10   = 18'sd52429;
    localparam logic signed [17:0] ANGLE_GAIN = 18'sd375;
    localparam logic signed [17:0] ACCEL_GAIN = 18'sd46080;

    localparam logic [1:0] MS_DIV10 = 2'd0;
    localparam logic [1:0] MS_ANG   = 2'd1;
    localparam logic [1:0] MS_RATE  = 2'd2;
    localparam logic [1:0] MS_ACC   = 2'd3;

    localparam logic [1:0] AO_NONE = 2'd0;
    localparam logic [1:0] AO_LOAD = 2'd1;
    localparam logic [1:0] AO_ADD  = 2'd2;

    localparam logic [2:0] C_NEVER   = 3'd0;
    localparam logic [2:0] C_ALWAYS  = 3'd1;
    localparam logic [2:0] C_NOSTART = 3'd2;
    localparam logic [2:0] C_DIVBUSY = 3'd3;
    localparam logic [2:0] C_OUTBUSY = 3'd4;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
        logic            axis;
        logic [1:0]      mul_sel;
        logic [1:0]      acc_op;
        logic            rate_ld;
        logic            div_start;
        logic            tilt_wr;
        logic            out_ld;
        logic            in_ld;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic div_busy;
        logic out_busy;
    } stat_t;

    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t c;
        c = '0;
        unique case (pc)
            5'd0:
            begin
                c.in_ld  = 1'b1;
                c.cond   = C_NOSTART;
                c.target = 5'd0;
            end
            5'd1:
            begin
                c.mul_sel = MS_DIV10;
            end
            5'd2:
            begin
                c.rate_ld = 1'b1;
                c.axis    = AXIS_X;
                c.mul_sel = MS_ANG;
            end
            5'd3:
            begin
                c.axis    = AXIS_X;
                c.acc_op  = AO_LOAD;
                c.mul_sel = MS_RATE;
            end
            5'd4:
            begin
                c.axis    = AXIS_X;
                c.acc_op  = AO_ADD;
                c.mul_sel = MS_ACC;
            end
            5'd5:
            begin
                c.acc_op = AO_ADD;
            end
            5'd6:
            begin
                c.div_start = 1'b1;
            end
            5'd7:
            begin
                c.cond   = C_DIVBUSY;
                c.target = 5'd7;
            end
            5'd8:
            begin
                c.axis    = AXIS_X;
                c.tilt_wr = 1'b1;
            end
            5'd9:
            begin
                c.axis    = AXIS_Y;
                c.mul_sel = MS_ANG;
            end
            5'd10:
            begin
                c.axis    = AXIS_Y;
                c.acc_op  = AO_LOAD;
                c.mul_sel = MS_RATE;
            end
            5'd11:
            begin
                c.axis    = AXIS_Y;
                c.acc_op  = AO_ADD;
                c.mul_sel = MS_ACC;
            end
            5'd12:
            begin
                c.acc_op = AO_ADD;
            end
            5'd13:
            begin
                c.div_start = 1'b1;
            end
            5'd14:
            begin
                c.cond   = C_DIVBUSY;
                c.target = 5'd14;
            end
            5'd15:
            begin
                c.axis    = AXIS_Y;
                c.tilt_wr = 1'b1;
            end
            5'd16:
            begin
                c.out_ld = 1'b1;
                c.cond   = C_OUTBUSY;
                c.target = 5'd16;
            end
            default:
            begin
                c.cond   = C_ALWAYS;
                c.target = 5'd0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/tcf_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module tcf_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  tcf_pkg::stat_t stat,
    output tcf_pkg::ctl_t  cw
);
    import tcf_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:  take = 1'b1;
            C_NOSTART: take = !stat.start;
            C_DIVBUSY: take = stat.div_busy;
            C_OUTBUSY: take = stat.out_busy;
            default:   take = 1'b0;
        endcase
        pc_next = take ? cw.target : pc_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/tcf_div.sv =====
// reciprocal-multiply signed divide by 625 with rounding and 24-bit saturation
module tcf_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [tcf_pkg::ACC_W-1:0] num,
    output logic                            busy,
    output logic signed [tcf_pkg::QUO_W-1:0] quo
);
    import tcf_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic [QUO_W-1:0]  qest_reg;
    logic [ACC_W-1:0]  back_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [ACC_W-1:0]  absn;
    logic [ACC_W-1:0]  mag;
    logic [EST_W-1:0]  est_prod;
    logic [ACC_W-1:0]  back_sum;
    logic [ACC_W-1:0]  rem_full;
    logic              qcorr;

    always_comb
    begin
        absn     = num[ACC_W-1] ? ('0 - num) : num;
        mag      = absn + ROUND_ADD;
        // estimate is never above the true quotient and short by at most one
        est_prod = EST_W'(mag_reg[MHI_LSB+MHI_W-1:MHI_LSB]) * EST_W'(RECIP_625);
        // 625 = 512 + 64 + 32 + 16 + 1
        back_sum = ACC_W'({qest_reg, 9'b0}) + ACC_W'({qest_reg, 6'b0})
                 + ACC_W'({qest_reg, 5'b0}) + ACC_W'({qest_reg, 4'b0})
                 + ACC_W'(qest_reg);
        rem_full = mag_reg - back_reg;
        qcorr    = (rem_full >= ACC_W'(DIVISOR));
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[ACC_W-1];
            mag_reg <= mag;
        end
        else if (busy_reg)
        begin
            unique case (cnt_reg)
                DS_EST:  qest_reg <= est_prod[RECIP_SH+QUO_W-1:RECIP_SH];
                DS_BACK: back_reg <= back_sum;
                DS_FIX:  q_reg    <= qest_reg + QUO_W'(qcorr);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            quo = q_reg[QUO_W-1] ? {1'b0, {(QUO_W-1){1'b1}}} : q_reg;
        end
        else
        begin
            quo = (q_reg[QUO_W-1] && (q_reg[QUO_W-2:0] != '0))
                ? {1'b1, {(QUO_W-1){1'b0}}} : ('0 - q_reg);
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == DIV_STEPS)
        else $error("divider did not start");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");
`endif

endmodule

// ===== sv/tcf_dp.sv =====
// datapath: input latch, shared multiplier, accumulator, rates and tilt state
module tcf_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcf_pkg::ctl_t                    cw,
    input  logic                             in_acc,
    input  logic signed [15:0]               gx,
    input  logic signed [15:0]               gy,
    input  logic signed [15:0]               ax,
    input  logic signed [15:0]               ay,
    input  logic [9:0]                       dt,
    input  logic signed [tcf_pkg::QUO_W-1:0] quo,
    output logic signed [tcf_pkg::ACC_W-1:0] acc,
    output logic signed [tcf_pkg::QUO_W-1:0] tilt_x,
    output logic signed [tcf_pkg::QUO_W-1:0] tilt_y
);
    import tcf_pkg::*;

    logic [16:0]              gxmag_reg;
    logic                     gxneg_reg;
    logic signed [16:0]       ry_reg;
    logic signed [16:0]       rx_reg;
    logic signed [15:0]       ax_reg;
    logic signed [15:0]       ay_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [QUO_W-1:0]  tilt_x_reg;
    logic signed [QUO_W-1:0]  tilt_y_reg;

    logic [16:0]        gx_ext;
    logic [16:0]        gy_ext;
    logic               gy_dead;
    logic [16:0]        dt96;
    logic [11:0]        qmag;
    logic [16:0]        rx_mag;
    logic signed [24:0] op_a;
    logic signed [17:0] op_b;
    logic signed [42:0] prod_full;

    always_comb
    begin
        gx_ext  = {gx[15], gx};
        gy_ext  = {gy[15], gy};
        gy_dead = (gy == 16'sd0) || (gy == 16'sd1) || (gy == -16'sd1);
        dt96    = {1'b0, dt, 6'b0} + {2'b0, dt, 5'b0};
        qmag    = prod_reg[30:19];
        rx_mag  = {5'd0, qmag};
    end

    always_comb
    begin
        unique case (cw.mul_sel)
            MS_DIV10:
            begin
                op_a = {8'd0, gxmag_reg};
                op_b = RECIP_10;
            end
            MS_ANG:
            begin
                op_a = (cw.axis == AXIS_Y) ? {tilt_y_reg[QUO_W-1], tilt_y_reg}
                                           : {tilt_x_reg[QUO_W-1], tilt_x_reg};
                op_b = ANGLE_GAIN;
            end
            MS_RATE:
            begin
                op_a = (cw.axis == AXIS_Y) ? {{8{ry_reg[16]}}, ry_reg}
                                           : {{8{rx_reg[16]}}, rx_reg};
                op_b = {1'b0, dt96};
            end
            default:
            begin
                op_a = (cw.axis == AXIS_Y) ? {{9{ax_reg[15]}}, ax_reg}
                                           : {{9{ay_reg[15]}}, ay_reg};
                op_b = ACCEL_GAIN;
            end
        endcase
        prod_full = 43'(op_a) * 43'(op_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:0];
        if (in_acc)
        begin
            gxneg_reg <= gx[15];
            gxmag_reg <= gx[15] ? (17'd0 - gx_ext) : gx_ext;
            ry_reg    <= gy_dead ? 17'sd0 : (17'd0 - gy_ext);
            ax_reg    <= ax;
            ay_reg    <= ay;
        end
        if (cw.rate_ld)
        begin
            rx_reg <= (qmag <= 12'd1) ? 17'sd0
                    : (gxneg_reg ? (17'd0 - rx_mag) : rx_mag);
        end
        unique case (cw.acc_op)
            AO_LOAD: acc_reg <= prod_reg;
            AO_ADD:  acc_reg <= acc_reg + prod_reg;
            default: acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_x_reg <= '0;
            tilt_y_reg <= '0;
        end
        else if (cw.tilt_wr)
        begin
            if (cw.axis == AXIS_Y)
            begin
                tilt_y_reg <= quo;
            end
            else
            begin
                tilt_x_reg <= quo;
            end
        end
    end

    assign acc    = acc_reg;
    assign tilt_x = tilt_x_reg;
    assign tilt_y = tilt_y_reg;

endmodule

// ===== sv/two_axis_complementary_tilt_filter.sv =====
// top level of the two-axis complementary tilt filter
// sample flow: a new sample set is accepted only after the current one has run through two 3-step
// divide-by-625 passes plus the microcode steps around the shared multiplier
// a finished beat waits in the output register while the next sample is accepted
// reset clears both tilt angles, step_time_ms, the step counter and out_valid
module two_axis_complementary_tilt_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] acc_x,
    input  logic signed [15:0] acc_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] angle_x,
    output logic signed [23:0] angle_y
);
    import tcf_pkg::*;

    ctl_t                    cw;
    stat_t                   stat;
    logic                    in_acc;
    logic                    out_busy;
    logic                    out_load;
    logic                    div_busy;
    logic signed [ACC_W-1:0] acc;
    logic signed [QUO_W-1:0] quo;
    logic signed [QUO_W-1:0] tilt_x;
    logic signed [QUO_W-1:0] tilt_y;

    logic [9:0]              step_time_ms_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [QUO_W-1:0] angle_x_reg;
    logic signed [QUO_W-1:0] angle_y_reg;

    assign in_ready = cw.in_ld;
    assign in_acc   = in_valid && cw.in_ld;
    assign out_busy = out_valid_reg && !out_ready;
    assign out_load = cw.out_ld && !out_busy;

    assign stat.start    = in_valid;
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_busy;

    tcf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw)
    );

    tcf_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cw     (cw),
        .in_acc (in_acc),
        .gx     (gyro_x),
        .gy     (gyro_y),
        .ax     (acc_x),
        .ay     (acc_y),
        .dt     (step_time_ms_reg),
        .quo    (quo),
        .acc    (acc),
        .tilt_x (tilt_x),
        .tilt_y (tilt_y)
    );

    tcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cw.div_start),
        .num   (acc),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_ms_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_time_ms_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            angle_x_reg <= tilt_x;
            angle_y_reg <= tilt_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_x   = angle_x_reg;
    assign angle_y   = angle_y_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while sample in flight");
    a_tilt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cw.tilt_wr |-> !div_busy)
        else $error("tilt written before divide finished");
    a_out_matches_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && angle_x_reg == tilt_x && angle_y_reg == tilt_y)
        else $error("output beat differs from tilt state");
    a_div_idle_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !div_busy)
        else $error("divider busy at sample accept");
`endif

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the two-axis complementary tilt filter
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 80;

    class tilt_scoreboard;
        typedef struct {
            logic signed [23:0] x;
            logic signed [23:0] y;
        } angle_pair_t;

        longint tilt_x = 0;
        longint tilt_y = 0;
        longint step_ms = 0;
        int errors = 0;
        angle_pair_t expected_angles[$];

        function void set_step_time(logic [9:0] v);
            step_ms = v;
        endfunction

        function longint dead_zone(longint r);
            return (r <= 1 && r >= -1) ? 0 : r;
        endfunction

        function longint blend_axis(longint angle, longint rate, longint acc);
            longint n;
            longint q;
            n = 375 * angle + 96 * rate * step_ms + 46080 * acc;
            if (n >= 0)
                q = (n + 312) / 625;
            else
                q = -((-n + 312) / 625);
            if (q > 8388607)
                q = 8388607;
            if (q < -8388608)
                q = -8388608;
            return q;
        endfunction

        function void note_sample(logic signed [15:0] gx, logic signed [15:0] gy,
                                  logic signed [15:0] ax, logic signed [15:0] ay);
            angle_pair_t p;
            longint rx;
            longint ry;
            rx = dead_zone(longint'(gx) / 10);
            ry = dead_zone(longint'(gy));
            tilt_x = blend_axis(tilt_x, rx, longint'(ay));
            tilt_y = blend_axis(tilt_y, -ry, longint'(ax));
            p.x = tilt_x[23:0];
            p.y = tilt_y[23:0];
            expected_angles.push_back(p);
        endfunction

        function void check_angles(logic signed [23:0] ax, logic signed [23:0] ay);
            angle_pair_t p;
            if (expected_angles.size() == 0)
            begin
                $error("unexpected output beat angle_x %0d angle_y %0d", ax, ay);
                errors++;
                return;
            end
            p = expected_angles.pop_front();
            if (ax !== p.x)
            begin
                $error("angle_x expected %0d got %0d", p.x, ax);
                errors++;
            end
            if (ay !== p.y)
            begin
                $error("angle_y expected %0d got %0d", p.y, ay);
                errors++;
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [9:0]         cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] gyro_x = '0;
    logic signed [15:0] gyro_y = '0;
    logic signed [15:0] acc_x = '0;
    logic signed [15:0] acc_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] angle_x;
    logic signed [23:0] angle_y;

    tilt_scoreboard sb;

    two_axis_complementary_tilt_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .gyro_x      (gyro_x),
        .gyro_y      (gyro_y),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle_x     (angle_x),
        .angle_y     (angle_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top NOT OK");
        $finish;
    end

    // output side: stretches of always-ready, random, sparse and long stalls
    int rx_mode = 0;
    int stretch_left = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_angles(angle_x, angle_y);
        if (stretch_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(50, 400);
        end
        else
            stretch_left--;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left == 0)
                begin
                    out_ready <= 1'b1;
                    stall_left = $urandom_range(1, 120);
                end
                else
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
            end
        endcase
    end

    task automatic send_sample(input logic signed [15:0] gx, input logic signed [15:0] gy,
                               input logic signed [15:0] ax, input logic signed [15:0] ay);
        in_valid <= 1'b1;
        gyro_x   <= gx;
        gyro_y   <= gy;
        acc_x    <= ax;
        acc_y    <= ay;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(gx, gy, ax, ay);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_step_time(input logic [9:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_step_time(v);
    endtask

    function automatic logic signed [15:0] pick_edge();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            4: return 16'sh0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        int sent;
        int mode;
        int run_left;
        int burst_left;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] held_gx;
        logic signed [15:0] held_gy;
        sent = 0;
        run_left = 0;
        burst_left = $urandom_range(1, 40);
        mode = 0;
        held_gx = '0;
        held_gy = '0;
        while (sent < count)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 3);
                run_left = $urandom_range(1, 12);
                held_gx = ($urandom_range(0, 1) != 0) ? pick_edge() : 16'($urandom);
                held_gy = ($urandom_range(0, 1) != 0) ? pick_edge() : 16'($urandom);
            end
            run_left--;
            case (mode)
                0:
                begin
                    gx = 16'($urandom);
                    gy = 16'($urandom);
                    ax = 16'($urandom);
                    ay = 16'($urandom);
                end
                1:
                begin
                    gx = pick_edge();
                    gy = pick_edge();
                    ax = pick_edge();
                    ay = pick_edge();
                end
                2:
                begin
                    // around the rate deadband
                    gx = 16'($signed($urandom_range(0, 60)) - 30);
                    gy = 16'($signed($urandom_range(0, 6)) - 3);
                    ax = 16'($signed($urandom_range(0, 200)) - 100);
                    ay = 16'($signed($urandom_range(0, 200)) - 100);
                end
                default:
                begin
                    // steady rotation drives the angles toward saturation
                    gx = held_gx;
                    gy = held_gy;
                    ax = ($urandom_range(0, 1) != 0) ? pick_edge() : 16'($urandom);
                    ay = ($urandom_range(0, 1) != 0) ? pick_edge() : 16'($urandom);
                end
            endcase
            send_sample(gx, gy, ax, ay);
            sent++;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0 && sent < count)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 80)) @(posedge clk);
                end
            end
        end
        drain();
    endtask

    initial
    begin
        logic [9:0] step_list[8];
        sb = new();
        step_list[0] = 10'd1023;
        step_list[1] = 10'd0;
        step_list[2] = 10'd1;
        step_list[3] = 10'd1001;
        step_list[4] = 10'($urandom_range(2, 999));
        step_list[5] = 10'd1000;
        step_list[6] = 10'($urandom);
        step_list[7] = 10'd1023;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // interval still at its reset value
        send_sample(16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        drain();

        write_step_time(10'd1000);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd19, 16'sd1, 16'sd0, 16'sd0);
        send_sample(-16'sd19, -16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd20, 16'sd2, 16'sd0, 16'sd0);
        send_sample(-16'sd20, -16'sd2, 16'sd0, 16'sd0);
        send_sample(16'sd29, 16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        drain();

        // saturation both ways
        write_step_time(10'd1023);
        repeat (6) send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
        repeat (6) send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
        drain();

        foreach (step_list[i])
        begin
            write_step_time(step_list[i]);
            run_random(160);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected beats never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
